@@ sv/heightfield_lambert_shader_unit_macros.svh @@
// Assertion macros for the heightfield Lambert shader.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef HEIGHTFIELD_LAMBERT_SHADER_UNIT_MACROS_SVH
`define HEIGHTFIELD_LAMBERT_SHADER_UNIT_MACROS_SVH

// checked only outside reset
`define HLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked during reset too
`define HLS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ sv/hls_pkg.sv @@
// Shared constants and types of the heightfield Lambert shader.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hls_pkg;
    localparam int FRAC    = 16;
    localparam int MAX_DIM = 4096;
    localparam int NSTEP   = FRAC + 1;          // one result bit per stage
    localparam int VW      = 16;                // component magnitude
    localparam int SW      = 32;                // squared length
    localparam int TW      = 2 * VW + 2 * FRAC; // |v|^2 << 2F
    localparam int QW      = SW + NSTEP;        // m * S
    localparam int PW      = TW + 4;            // candidate c^2 * S
    localparam int MW      = NSTEP;             // unit component magnitude
    localparam int NLANE   = 6;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_INVERT  = 3'd1;
    localparam logic [2:0] REG_LIGHT_X = 3'd2;
    localparam logic [2:0] REG_LIGHT_Y = 3'd3;
    localparam logic [2:0] REG_LIGHT_Z = 3'd4;

    typedef struct packed {
        logic          neg;
        logic [SW-1:0] s;
        logic [TW-1:0] t;
    } lane_in_t;

    typedef struct packed {
        logic                point_mode;
        logic                invert;
        logic signed [15:0]  lx;
        logic signed [15:0]  ly;
        logic signed [15:0]  lz;
    } cfg_t;
endpackage
`default_nettype wire

@@ sv/hls_front.sv @@
// Front end: builds normal and light vectors, squares them, sums lengths.
// Three register stages. Depends on hls_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hls_front (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        en,
    input  wire                        in_valid,
    input  wire [63:0]                 in_data,
    input  wire                        in_interior,
    input  hls_pkg::cfg_t              cfg,
    output logic                       out_valid,
    output logic                       out_zero,
    output hls_pkg::lane_in_t [5:0]    out_lane
);
    import hls_pkg::*;

    logic [7:0]  hl, hr, hu, hd, hc;
    logic [11:0] px, py;
    assign hl = in_data[7:0];
    assign hr = in_data[15:8];
    assign hu = in_data[23:16];
    assign hd = in_data[31:24];
    assign hc = in_data[39:32];
    assign px = in_data[51:40];
    assign py = in_data[63:52];

    // stage A: signed components
    logic               a_valid_reg, a_zero_reg;
    logic signed [17:0] a_v_reg [NLANE];
    logic signed [17:0] a_v_next [NLANE];
    logic               a_zero_next;

    always_comb begin
        a_v_next[0] = 18'(signed'({1'b0, hl})) - 18'(signed'({1'b0, hr}));
        a_v_next[1] = 18'(signed'({1'b0, hu})) - 18'(signed'({1'b0, hd}));
        a_v_next[2] = 18'sd2;
        if (cfg.point_mode) begin
            a_v_next[3] = 18'(cfg.lx) - 18'(signed'({1'b0, px}));
            a_v_next[4] = 18'(cfg.ly) - 18'(signed'({1'b0, py}));
            a_v_next[5] = 18'(cfg.lz) - 18'(signed'({1'b0, hc}));
        end else begin
            a_v_next[3] = 18'(cfg.lx);
            a_v_next[4] = 18'(cfg.ly);
            a_v_next[5] = 18'(cfg.lz);
        end
        a_zero_next = !in_interior || ({1'b0, px} >= 13'(MAX_DIM))
                      || ({1'b0, py} >= 13'(MAX_DIM));
    end

    // stage B: magnitudes and squares
    logic                 b_valid_reg, b_zero_reg;
    logic                 b_neg_reg [NLANE];
    logic [SW-1:0]        b_sq_reg  [NLANE];
    logic [VW-1:0]        a_mag     [NLANE];

    always_comb begin
        for (int i = 0; i < NLANE; i++) begin
            a_mag[i] = a_v_reg[i][17] ? VW'(-a_v_reg[i]) : VW'(a_v_reg[i]);
        end
    end

    // stage C: lengths and scaled targets
    logic          sl_zero;
    logic [SW-1:0] sn, sl;
    assign sn = b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
    assign sl = b_sq_reg[3] + b_sq_reg[4] + b_sq_reg[5];
    assign sl_zero = (sl == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            out_valid   <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            out_valid   <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_zero_reg <= a_zero_next;
            b_zero_reg <= a_zero_reg;
            out_zero   <= b_zero_reg || sl_zero;
            for (int i = 0; i < NLANE; i++) begin
                a_v_reg[i]       <= a_v_next[i];
                b_neg_reg[i]     <= a_v_reg[i][17];
                b_sq_reg[i]      <= SW'(a_mag[i]) * SW'(a_mag[i]);
                out_lane[i].neg  <= b_neg_reg[i];
                out_lane[i].s    <= (i < 3) ? sn : sl;
                out_lane[i].t    <= TW'(b_sq_reg[i]) << (2 * FRAC);
            end
        end
    end
endmodule
`default_nettype wire

@@ sv/hls_norm_lane.sv @@
// One normalization lane: floor(|v| * 2^F / sqrt(S)), one bit per stage,
// with c^2*S kept incrementally. Depends on hls_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hls_norm_lane (
    input  wire                          aclk,
    input  wire                          en,
    input  hls_pkg::lane_in_t            in_lane,
    output logic signed [hls_pkg::MW:0]  unit
);
    import hls_pkg::*;

    logic [PW-1:0] p_reg [NSTEP];
    logic [QW-1:0] q_reg [NSTEP];
    logic [MW-1:0] m_reg [NSTEP];
    logic [SW-1:0] s_reg [NSTEP];
    logic [TW-1:0] t_reg [NSTEP];
    logic          n_reg [NSTEP];

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        localparam int B = FRAC - k;
        logic [PW-1:0] p_in, cand;
        logic [QW-1:0] q_in;
        logic [MW-1:0] m_in;
        logic [SW-1:0] s_in;
        logic [TW-1:0] t_in;
        logic          n_in, take;

        if (k == 0) begin : g_first
            assign p_in = '0;
            assign q_in = '0;
            assign m_in = '0;
            assign s_in = in_lane.s;
            assign t_in = in_lane.t;
            assign n_in = in_lane.neg;
        end else begin : g_next
            assign p_in = p_reg[k-1];
            assign q_in = q_reg[k-1];
            assign m_in = m_reg[k-1];
            assign s_in = s_reg[k-1];
            assign t_in = t_reg[k-1];
            assign n_in = n_reg[k-1];
        end

        // (m + 2^b)^2 S = m^2 S + 2^(b+1) m S + 2^(2b) S
        assign cand = p_in + (PW'(q_in) << (B + 1)) + (PW'(s_in) << (2 * B));
        assign take = (cand <= PW'(t_in));

        always_ff @(posedge aclk) begin
            if (en) begin
                p_reg[k] <= take ? cand : p_in;
                q_reg[k] <= take ? q_in + (QW'(s_in) << B) : q_in;
                m_reg[k] <= take ? (m_in | (MW'(1) << B)) : m_in;
                s_reg[k] <= s_in;
                t_reg[k] <= t_in;
                n_reg[k] <= n_in;
            end
        end
    end

    assign unit = n_reg[NSTEP-1] ? -$signed({1'b0, m_reg[NSTEP-1]})
                                 :  $signed({1'b0, m_reg[NSTEP-1]});
endmodule
`default_nettype wire

@@ sv/hls_dot.sv @@
// Dot product of the unit vectors, scaling by 255 and clamping.
// Three register stages, the last one is the output register. Depends on hls_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hls_dot (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                en,
    input  wire                                in_valid,
    input  wire                                in_zero,
    input  wire                                invert,
    input  wire signed [hls_pkg::MW:0]         un [3],
    input  wire signed [hls_pkg::MW:0]         ul [3],
    output logic                               out_valid,
    output logic [7:0]                         intensity
);
    import hls_pkg::*;

    localparam int PRW = 2 * (MW + 1);
    localparam int DW  = PRW + 2;

    logic                  p_valid_reg, p_zero_reg;
    logic signed [PRW-1:0] prod_reg [3];
    logic                  d_valid_reg, d_zero_reg;
    logic signed [DW-1:0]  dot_reg;
    logic signed [DW-1:0]  sum;
    logic [DW-1:0]         d;
    logic [DW+7:0]         scaled;
    logic [7:0]            res;

    assign sum = DW'(prod_reg[0]) + DW'(prod_reg[1]) + DW'(prod_reg[2]);

    always_comb begin
        d      = DW'(dot_reg) >> FRAC;
        scaled = ((DW+8)'(d) * (DW+8)'(255)) >> FRAC;
        if (d_zero_reg || dot_reg <= 0) begin
            res = '0;
        end else if (scaled > (DW+8)'(255)) begin
            res = 8'd255;
        end else begin
            res = scaled[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            out_valid   <= 1'b0;
        end else if (en) begin
            p_valid_reg <= in_valid;
            d_valid_reg <= p_valid_reg;
            out_valid   <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_zero_reg <= in_zero;
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= PRW'(un[i]) * PRW'(ul[i]);
            end
            d_zero_reg <= p_zero_reg;
            dot_reg    <= invert ? -sum : sum;
            intensity  <= res;
        end
    end
endmodule
`default_nettype wire

@@ sv/heightfield_lambert_shader_unit.sv @@
// Top level of the heightfield Lambert shader: APB registers, pipeline glue.
// Depends on hls_pkg, hls_front, hls_norm_lane, hls_dot and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "heightfield_lambert_shader_unit_macros.svh"
// Shades one pixel per clock unless the output stalls. Each request carries the
// four neighbour heights, the center height and the coordinates; the result is
// the Lambert grey level 0..255. Stages: 3 front (vectors, squares, lengths),
// 17 normalize (one quotient bit each, six lanes in parallel), 3 dot/scale.
// The whole pipeline advances only while the output register is empty or being
// taken, so a stalled result holds everything behind it and loses nothing.
// Registers (APB, byte address 4*i): 0 point_light_mode, 1 invert_normals,
// 2 light_x, 3 light_y, 4 light_z (signed 16 bit). Write them only while idle.
module heightfield_lambert_shader_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // height_left, height_right, height_up, height_down, height_center,
    // pixel_x[11:0], pixel_y[11:0]
    input  wire  [63:0] s_tdata,
    // interior
    input  wire         s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // intensity
    output logic [7:0]  m_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hls_pkg::*;

    hls_pkg::cfg_t cfg_reg;
    logic          wr;
    logic          en;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.point_mode <= 1'b0;
            cfg_reg.invert     <= 1'b0;
            cfg_reg.lx         <= 16'sd0;
            cfg_reg.ly         <= 16'sd0;
            cfg_reg.lz         <= 16'sd1;
        end else if (wr) begin
            case (paddr[4:2])
                REG_MODE:    cfg_reg.point_mode <= pwdata[0];
                REG_INVERT:  cfg_reg.invert     <= pwdata[0];
                REG_LIGHT_X: cfg_reg.lx         <= pwdata[15:0];
                REG_LIGHT_Y: cfg_reg.ly         <= pwdata[15:0];
                REG_LIGHT_Z: cfg_reg.lz         <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_MODE:    prdata = {31'd0, cfg_reg.point_mode};
            REG_INVERT:  prdata = {31'd0, cfg_reg.invert};
            REG_LIGHT_X: prdata = {{16{cfg_reg.lx[15]}}, cfg_reg.lx};
            REG_LIGHT_Y: prdata = {{16{cfg_reg.ly[15]}}, cfg_reg.ly};
            REG_LIGHT_Z: prdata = {{16{cfg_reg.lz[15]}}, cfg_reg.lz};
            default:     prdata = '0;
        endcase
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic                       f_valid, f_zero;
    hls_pkg::lane_in_t [5:0]    f_lane;

    hls_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .in_data     (s_tdata),
        .in_interior (s_tuser),
        .cfg         (cfg_reg),
        .out_valid   (f_valid),
        .out_zero    (f_zero),
        .out_lane    (f_lane)
    );

    logic signed [MW:0] unit [NLANE];
    for (genvar i = 0; i < NLANE; i++) begin : g_lane
        hls_norm_lane u_lane (
            .aclk    (aclk),
            .en      (en),
            .in_lane (f_lane[i]),
            .unit    (unit[i])
        );
    end

    // valid and zero flags ride alongside the normalize stages
    logic valid_reg [NSTEP];
    logic zero_reg  [NSTEP];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NSTEP; k++) valid_reg[k] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= f_valid;
            for (int k = 1; k < NSTEP; k++) valid_reg[k] <= valid_reg[k-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= f_zero;
            for (int k = 1; k < NSTEP; k++) zero_reg[k] <= zero_reg[k-1];
        end
    end

    logic signed [MW:0] un [3];
    logic signed [MW:0] ul [3];
    assign un[0] = unit[0];
    assign un[1] = unit[1];
    assign un[2] = unit[2];
    assign ul[0] = unit[3];
    assign ul[1] = unit[4];
    assign ul[2] = unit[5];

    hls_dot u_dot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (valid_reg[NSTEP-1]),
        .in_zero   (zero_reg[NSTEP-1]),
        .invert    (cfg_reg.invert),
        .un        (un),
        .ul        (ul),
        .out_valid (m_tvalid),
        .intensity (m_tdata)
    );

    `HLS_ASSERT(a_ready_follows_out, s_tready == (!m_tvalid || m_tready), "ready mismatch")
    `HLS_ASSERT(a_lz_write, (wr && paddr[4:2] == REG_LIGHT_Z) |=> cfg_reg.lz == $past(pwdata[15:0]), "light_z write lost")
    `HLS_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "output valid after reset")
endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking bench for the heightfield Lambert shader: random and directed pixels,
// APB register settings, stalls on both streams. Depends on hls_pkg and the shader top.
`timescale 1ns / 1ps
module testbench;
    import hls_pkg::*;

    localparam int FB        = 16;
    localparam int LATENCY   = 23;
    localparam int WD_LIMIT  = 20000;

    typedef struct packed {
        logic        interior;
        logic [11:0] py;
        logic [11:0] px;
        logic [7:0]  hc;
        logic [7:0]  hd;
        logic [7:0]  hu;
        logic [7:0]  hr;
        logic [7:0]  hl;
    } pixel_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [7:0]  m_tdata;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    heightfield_lambert_shader_unit uut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    cfg_t         shade_cfg;
    pixel_t       pixel_q[$];
    logic [7:0]   grey_q[$];
    int           mismatches = 0;
    int           idle_cycles = 0;
    bit           no_idle = 0;
    bit           hold_sink = 0;
    int           hold_count = 0;
    // accept flag captured at the posedge so the driver sees a settled handshake
    logic         s_tready_q = 0;

    // floor(|v| * 2^FB / sqrt(s)), signed like v
    function automatic longint unit_comp(longint v, longint s);
        longint mag, m, c;
        logic [127:0] lhs, rhs;
        mag = v < 0 ? -v : v;
        m = 0;
        rhs = 128'(mag * mag) << (2 * FB);
        for (int b = FB; b >= 0; b--) begin
            c = m | (longint'(1) << b);
            lhs = 128'(c * c) * 128'(s);
            if (lhs <= rhs) m = c;
        end
        return v < 0 ? -m : m;
    endfunction

    function automatic logic [7:0] shade(pixel_t p, cfg_t c);
        longint n[3], l[3], sn, sl, dot, d, r;
        if (!p.interior) return 8'd0;
        n[0] = longint'(p.hl) - longint'(p.hr);
        n[1] = longint'(p.hu) - longint'(p.hd);
        n[2] = 2;
        if (c.point_mode) begin
            l[0] = longint'(c.lx) - longint'(p.px);
            l[1] = longint'(c.ly) - longint'(p.py);
            l[2] = longint'(c.lz) - longint'(p.hc);
        end else begin
            l[0] = c.lx; l[1] = c.ly; l[2] = c.lz;
        end
        sn = 0; sl = 0;
        for (int i = 0; i < 3; i++) begin
            sn += n[i] * n[i];
            sl += l[i] * l[i];
        end
        if (sl == 0) return 8'd0;
        dot = 0;
        for (int i = 0; i < 3; i++)
            dot += (c.invert ? -unit_comp(n[i], sn) : unit_comp(n[i], sn)) * unit_comp(l[i], sl);
        if (dot <= 0) return 8'd0;
        d = dot >>> FB;
        r = (d * 255) >>> FB;
        return r > 255 ? 8'd255 : 8'(r);
    endfunction

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_MODE:    shade_cfg.point_mode = val[0];
            REG_INVERT:  shade_cfg.invert = val[0];
            REG_LIGHT_X: shade_cfg.lx = val[15:0];
            REG_LIGHT_Y: shade_cfg.ly = val[15:0];
            REG_LIGHT_Z: shade_cfg.lz = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_light(bit pm, bit inv, int x, int y, int z);
        apb_write(REG_MODE, 32'(pm));
        apb_write(REG_INVERT, 32'(inv));
        apb_write(REG_LIGHT_X, 32'(x));
        apb_write(REG_LIGHT_Y, 32'(y));
        apb_write(REG_LIGHT_Z, 32'(z));
    endtask

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p = '0;
        p[31:0] = $urandom;
        p[63:32] = $urandom;
        p.interior = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 3) != 0) begin
            // gentle slopes near the light
            p.hr = p.hl + 8'($urandom_range(0, 40)) - 8'd20;
            p.hd = p.hu + 8'($urandom_range(0, 40)) - 8'd20;
            if (shade_cfg.point_mode && $urandom_range(0, 1)) begin
                p.px = 12'(shade_cfg.lx) + 12'($urandom_range(0, 200)) - 12'd100;
                p.py = 12'(shade_cfg.ly) + 12'($urandom_range(0, 200)) - 12'd100;
            end
        end
        return p;
    endfunction

    task automatic wait_drained();
        while (pixel_q.size() != 0 || grey_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    // sender
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready_q) begin
                if (pixel_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 20)) begin
                    s_tdata  <= pixel_q[0][63:0];
                    s_tuser  <= pixel_q[0].interior;
                    s_tvalid <= 1;
                end else
                    s_tvalid <= 0;
            end
            if (hold_count > 0) m_tready <= 0;
            else m_tready <= no_idle || $urandom_range(0, 99) >= 20;
        end
    end

    always @(posedge aclk) begin
        s_tready_q <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            grey_q.push_back(shade(pixel_q[0], shade_cfg));
            void'(pixel_q.pop_front());
        end
    end

    // receiver hold-off counter
    always @(posedge aclk) begin
        if (hold_count > 0) hold_count <= hold_count - 1;
        else if (hold_sink) begin
            hold_count <= 300;
            hold_sink <= 0;
        end
    end

    // result checker and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                if (grey_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected intensity %0d", m_tdata);
                end else begin
                    if (m_tdata !== grey_q[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("intensity mismatch: expected %0d actual %0d",
                                     grey_q[0], m_tdata);
                    end
                    void'(grey_q.pop_front());
                end
            end
            if (idle_cycles >= WD_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        pixel_t p;
        shade_cfg = '{point_mode: 0, invert: 0, lx: 0, ly: 0, lz: 1};
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: reset light (straight down the z axis)
        p = '{interior: 1, py: 5, px: 5, hc: 0, hd: 0, hu: 0, hr: 0, hl: 0};
        pixel_q.push_back(p);
        p.hl = 255; p.hr = 0; pixel_q.push_back(p);
        p.hl = 0; p.hr = 255; p.hu = 255; p.hd = 0; pixel_q.push_back(p);
        p.hl = 255; p.hr = 255; p.hu = 0; p.hd = 255; pixel_q.push_back(p);
        p.interior = 0; pixel_q.push_back(p);
        p.interior = 1; p.px = 12'hFFF; p.py = 12'hFFF; pixel_q.push_back(p);
        wait_drained();

        // zero directional light, then inverted extremes
        set_light(0, 0, 0, 0, 0);
        p = '{interior: 1, py: 1, px: 1, hc: 9, hd: 3, hu: 7, hr: 1, hl: 4};
        pixel_q.push_back(p);
        wait_drained();
        set_light(0, 1, -32768, 32767, -32768);
        pixel_q.push_back(p);
        p.hl = 0; p.hr = 255; p.hu = 0; p.hd = 255; pixel_q.push_back(p);
        p.hl = 255; p.hr = 0; pixel_q.push_back(p);
        wait_drained();

        // point light, including light exactly at the pixel
        set_light(1, 0, 100, 200, 50);
        p = '{interior: 1, py: 200, px: 100, hc: 50, hd: 8, hu: 8, hr: 8, hl: 8};
        pixel_q.push_back(p);
        p.hc = 0; pixel_q.push_back(p);
        p.px = 12'hFFF; p.py = 0; p.hc = 255; pixel_q.push_back(p);
        p.px = 0; p.py = 12'hFFF; pixel_q.push_back(p);
        wait_drained();
        set_light(1, 1, 32767, -32768, 32767);
        p = '{interior: 1, py: 12'hFFF, px: 0, hc: 255, hd: 255, hu: 0, hr: 255, hl: 0};
        pixel_q.push_back(p);
        p.interior = 0; pixel_q.push_back(p);
        wait_drained();

        // random phases over several light settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_light(0, 0, 1, -2, 3);
                1: set_light(1, 0, 2000, 1500, 300);
                2: set_light(0, 1, $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535));
                3: set_light(1, 1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                             $urandom_range(0, 600) - 300);
                4: set_light(0, 0, -5, 7, 40);
                default: set_light(1, 0, 500, 500, -32768);
            endcase
            no_idle = (ph == 1);
            if (ph == 2) hold_sink = 1;
            for (int k = 0; k < 65; k++) pixel_q.push_back(rand_pixel());
            wait_drained();
        end

        if (mismatches == 0 && grey_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
